[rtl/ete_pkg.sv]
`timescale 1ns / 1ps
package ete_pkg;

  // Text store geometry
  localparam int MAX_TEXT   = 64;
  localparam int STORE_SIZE = MAX_TEXT + 2;
  localparam int STORE_AW   = $clog2(STORE_SIZE);
  localparam int CNT_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int CHAR_W     = 7;

  localparam logic [CNT_W-1:0] MAX_TEXT_C   = CNT_W'(MAX_TEXT);
  localparam logic [CNT_W-1:0] LOAD_LIMIT_C = CNT_W'(MAX_TEXT + 1);
  localparam logic [CNT_W-1:0] STORE_SIZE_C = CNT_W'(STORE_SIZE);

  // Character wheel
  localparam logic [CNT_W-1:0] WHEEL_LAST  = 7'd69;
  localparam logic [CNT_W-1:0] WHEEL_START = 7'd42;

  localparam logic [CHAR_W-1:0] CH_ACCEPT = 7'h3D;  // '='
  localparam logic [CHAR_W-1:0] CH_BACK   = 7'h3C;  // '<'
  localparam logic [CHAR_W-1:0] CH_CANCEL = 7'h5E;  // '^'
  localparam logic [CHAR_W-1:0] CH_LA     = 7'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_LZ     = 7'h7A;  // 'z'
  localparam logic [CHAR_W-1:0] CASE_OFS  = 7'd32;

  typedef enum logic [2:0] {
    FN_FWD   = 3'd0,
    FN_BACK  = 3'd1,
    FN_SHORT = 3'd2,
    FN_LONG  = 3'd3,
    FN_BEGIN = 3'd4,
    FN_LOAD  = 3'd5,
    FN_READ  = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_CONT   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_CANCEL = 2'd2
  } status_t;

  // Config register indexes
  localparam logic REG_MAX_LENGTH = 1'b0;

  typedef struct packed {
    logic [1:0]        status;
    logic [CHAR_W-1:0] wheel_char;
    logic [CNT_W-1:0]  cursor;
    logic [BYTE_W-1:0] read_char;
  } result_t;

  // Wheel layout: '=', digits, upper case, lower case, then "-_ !?<^"
  function automatic logic [CHAR_W-1:0] wheel_char_of(input logic [CNT_W-1:0] idx);
    logic [CHAR_W-1:0] ch;
    ch = CH_ACCEPT;
    if (idx == 7'd0) begin
      ch = CH_ACCEPT;
    end else if (idx <= 7'd10) begin
      ch = 7'h30 + (idx - 7'd1);
    end else if (idx <= 7'd36) begin
      ch = 7'h41 + (idx - 7'd11);
    end else if (idx <= 7'd62) begin
      ch = 7'h61 + (idx - 7'd37);
    end else begin
      case (idx)
        7'd63:   ch = 7'h2D;
        7'd64:   ch = 7'h5F;
        7'd65:   ch = 7'h20;
        7'd66:   ch = 7'h21;
        7'd67:   ch = 7'h3F;
        7'd68:   ch = CH_BACK;
        default: ch = CH_CANCEL;
      endcase
    end
    return ch;
  endfunction

endpackage

[rtl/encoder_text_entry.sv]
`timescale 1ns / 1ps
// Rotary-encoder text entry: wheel, cursor and a 66-byte text store.
// An accepted input transaction passes the result stage, then the output queue, before its result is on the output.
// Throughput: one transaction per cycle unless in_stall holds the input; the state update is
// combinational and the text store takes one write and one registered read per transaction.
// Reset (rst, synchronous): wheel at entry 42, cursor and load count at 0, max_length 64;
// store valid bits clear at once, so the whole store reads as zero with no clearing pass.
module encoder_text_entry import ete_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          func,
  input  logic [BYTE_W-1:0]   char_in,
  input  logic [CNT_W-1:0]    read_index,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [CHAR_W-1:0]   wheel_char,
  output logic [CNT_W-1:0]    cursor,
  output logic [BYTE_W-1:0]   read_char,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Architectural state
  logic [CNT_W-1:0]      max_length;
  logic [CNT_W-1:0]      wheel_index;
  logic [CNT_W-1:0]      cursor_pos;
  logic [CNT_W-1:0]      load_count;
  logic [STORE_SIZE-1:0] valid;

  logic [CNT_W-1:0]      wheel_next;
  logic [CNT_W-1:0]      cursor_next;
  logic [CNT_W-1:0]      load_next;
  status_t               status_next;

  // Result stage: one transaction waiting for its store read data
  logic                  a_valid;
  logic [1:0]            a_status;
  logic [CHAR_W-1:0]     a_wheel;
  logic [CNT_W-1:0]      a_cursor;
  logic                  a_hit;
  logic [BYTE_W-1:0]     a_fwd;
  logic                  a_vld;
  logic                  a_move;

  logic                  in_accept;
  logic                  fifo_ready;
  result_t               a_result;
  result_t               head;

  // Store access
  logic                  st_we;
  logic [STORE_AW-1:0]   st_waddr;
  logic [BYTE_W-1:0]     st_wdata;
  logic                  st_clear;
  logic                  rd_in_range;
  logic [STORE_AW-1:0]   st_raddr;
  logic [BYTE_W-1:0]     st_rdata;

  // Step helpers
  logic [CNT_W-1:0]      wi_clamp;
  logic [CHAR_W-1:0]     wc;
  logic [CHAR_W-1:0]     wc_upper;
  logic [CNT_W-1:0]      eff_len;
  logic [CNT_W-1:0]      cursor_adv;
  logic                  put_ok;
  logic                  load_ok;
  logic [CNT_W-1:0]      load_inc;

  assign pready    = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign a_move    = a_valid && fifo_ready;
  // Hold the input while the result stage cannot drain into the output queue
  assign in_stall  = a_valid && !fifo_ready;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_TEXT_C;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LENGTH)) begin
      max_length <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_LENGTH) ? {{(32-CNT_W){1'b0}}, max_length} : 32'd0;

  // ---------------------------------------------------------------------------
  // Step logic
  // ---------------------------------------------------------------------------
  // Out-of-range lengths fall back to the full text size
  assign eff_len = ((max_length >= 7'd1) && (max_length <= MAX_TEXT_C)) ? max_length
                                                                        : MAX_TEXT_C;

  assign wi_clamp = (wheel_index > WHEEL_LAST) ? WHEEL_LAST : wheel_index;
  assign wc       = wheel_char_of(wi_clamp);
  assign wc_upper = (wc inside {[CH_LA:CH_LZ]}) ? (wc - CASE_OFS) : wc;

  // A write at the cursor advances it unless the length limit is reached
  assign put_ok     = (cursor_pos < STORE_SIZE_C);
  assign cursor_adv = (cursor_pos < eff_len) ? (cursor_pos + 7'd1) : cursor_pos;

  assign load_ok  = (char_in != 8'd0) && (load_count < LOAD_LIMIT_C);
  assign load_inc = load_ok ? (load_count + 7'd1) : load_count;

  always_comb begin
    wheel_next  = wi_clamp;
    cursor_next = cursor_pos;
    load_next   = load_count;
    status_next = ST_CONT;
    st_we       = 1'b0;
    st_waddr    = cursor_pos[STORE_AW-1:0];
    st_wdata    = '0;
    st_clear    = 1'b0;
    case (func_t'(func))
      FN_FWD: begin
        if (wi_clamp < WHEEL_LAST) begin
          wheel_next = wi_clamp + 7'd1;
        end
      end
      FN_BACK: begin
        if (wi_clamp != 7'd0) begin
          wheel_next = wi_clamp - 7'd1;
        end
      end
      FN_SHORT: begin
        if (wc == CH_CANCEL) begin
          status_next = ST_CANCEL;
        end else if (wc == CH_BACK) begin
          // terminate at the cursor and back up one place
          st_we = put_ok;
          if (cursor_pos != 7'd0) begin
            cursor_next = cursor_pos - 7'd1;
          end
        end else if (wc == CH_ACCEPT) begin
          // refuse an empty text
          if (cursor_pos != 7'd0) begin
            st_we       = put_ok;
            status_next = ST_ACCEPT;
          end
        end else begin
          st_we       = put_ok;
          st_wdata    = {1'b0, wc};
          cursor_next = cursor_adv;
        end
      end
      FN_LONG: begin
        // cancel and back-up marks do nothing on a long press
        if ((wc != CH_CANCEL) && (wc != CH_BACK)) begin
          st_we       = put_ok;
          st_wdata    = {1'b0, wc_upper};
          cursor_next = cursor_adv;
        end
      end
      FN_BEGIN: begin
        st_clear    = 1'b1;
        cursor_next = '0;
        load_next   = '0;
        wheel_next  = WHEEL_START;
      end
      FN_LOAD: begin
        st_we       = load_ok;
        st_waddr    = load_count[STORE_AW-1:0];
        st_wdata    = char_in;
        load_next   = load_inc;
        cursor_next = (load_inc < eff_len) ? load_inc : eff_len;
      end
      FN_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_index <= WHEEL_START;
      cursor_pos  <= '0;
      load_count  <= '0;
      valid       <= '0;
    end else if (in_accept) begin
      wheel_index <= wheel_next;
      cursor_pos  <= cursor_next;
      load_count  <= load_next;
      if (st_clear) begin
        valid <= '0;
      end else if (st_we) begin
        valid[st_waddr] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Text store: read at read_index sees this transaction's write by forwarding
  // ---------------------------------------------------------------------------
  assign rd_in_range = (read_index < STORE_SIZE_C);
  assign st_raddr    = rd_in_range ? read_index[STORE_AW-1:0] : '0;

  ete_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (in_accept && st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (in_accept),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_status <= status_next;
      a_wheel  <= wheel_char_of(wheel_next);
      a_cursor <= cursor_next;
      a_hit    <= st_we && rd_in_range && (st_waddr == st_raddr);
      a_fwd    <= st_wdata;
      // a begin empties the store; unwritten entries read as zero
      a_vld    <= rd_in_range && !st_clear && valid[st_raddr];
    end
  end

  always_comb begin
    a_result.status     = a_status;
    a_result.wheel_char = a_wheel;
    a_result.cursor     = a_cursor;
    if (a_hit) begin
      a_result.read_char = a_fwd;
    end else if (a_vld) begin
      a_result.read_char = st_rdata;
    end else begin
      a_result.read_char = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue: takes up to two results while the receiver stalls
  // ---------------------------------------------------------------------------
  ete_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (a_valid),
    .push_data (a_result),
    .ready     (fifo_ready),
    .stall     (out_stall),
    .valid     (out_valid),
    .head      (head)
  );

  assign status     = head.status;
  assign wheel_char = head.wheel_char;
  assign cursor     = head.cursor;
  assign read_char  = head.read_char;

endmodule

[rtl/ete_ram.sv]
`timescale 1ns / 1ps
module ete_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ete_out_fifo.sv]
`timescale 1ns / 1ps
module ete_out_fifo import ete_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    ready,
  input  logic    stall,
  output logic    valid,
  output result_t head
);

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  logic       do_push;

  assign valid   = (count != 2'd0);
  assign pop     = valid && !stall;
  assign ready   = (count != 2'd2) || pop;
  assign do_push = push && ready;
  assign head    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/ete_checker.sv]
`timescale 1ns / 1ps
module ete_checker import ete_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          status,
  input logic [CHAR_W-1:0]   wheel_char,
  input logic [CNT_W-1:0]    cursor,
  input logic [BYTE_W-1:0]   read_char,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [2:0]          paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata,
  input logic                pready
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(wheel_char)
                               && $stable(cursor) && $stable(read_char))
    else $error("stalled result changed");

  // No result is left over after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Input stalls only while results back up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // An accept never comes with an empty text, and the cursor stays in range
  a_accept_cursor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor <= MAX_TEXT_C) && (status != 2'd3)
                  && ((status != ST_ACCEPT) || (cursor != 7'd0)))
    else $error("bad status or cursor");

  // A length write reads back
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LENGTH)
    |=> (paddr[2] != REG_MAX_LENGTH) || (prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0])))
    else $error("max_length readback mismatch");

endmodule

bind encoder_text_entry ete_checker u_ete_checker (.*);
